[sv/tccc_pkg.sv]
// ----------------------------------------------------------------------------
// Text console cursor control package
// Shared types, register indexes, character codes and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tccc_pkg;

  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 16;
  localparam int TAB_STEP     = 4;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_RETURN    = 8'd13;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  localparam logic [2:0] REG_GRID_COLUMNS = 3'd0;
  localparam logic [2:0] REG_GRID_ROWS    = 3'd1;
  localparam logic [2:0] REG_FORE_COLOR   = 3'd2;
  localparam logic [2:0] REG_BACK_COLOR   = 3'd3;
  localparam logic [2:0] REG_SCROLL_BLOCK = 3'd4;

  localparam logic [9:0]  RESET_GRID_COLUMNS = 10'd80;
  localparam logic [8:0]  RESET_GRID_ROWS    = 9'd25;
  localparam logic [23:0] RESET_FORE_COLOR   = 24'hD0D0D0;
  localparam logic [23:0] RESET_BACK_COLOR   = 24'h0A0A18;
  localparam logic [6:0]  RESET_SCROLL_BLOCK = 7'd8;

  typedef struct packed {
    logic [7:0] char_code;
    logic       in_panic;
  } item_t;

  typedef struct packed {
    logic        command_kind;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [7:0]  glyph_code;
    logic [23:0] draw_fore;
    logic [23:0] draw_back;
    logic [12:0] scroll_pixels;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [9:0]  grid_columns;
    logic [8:0]  grid_rows;
    logic [23:0] fore_color_reg;
    logic [23:0] back_color_reg;
    logic [6:0]  scroll_block;
  } cfg_t;

endpackage

`default_nettype wire

[sv/text_console_cursor_control.sv]
// ----------------------------------------------------------------------------
// Text console cursor control
// Turns a stream of character bytes into glyph draw and scroll commands.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one character word
// with its panic flag. The output channel (out_valid, out_stall, out_data)
// carries drawing commands, one or two per character; last_of_run marks the
// final command of each character. Control bytes such as return may cause
// no command at all.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes the grid size, colors and scroll block; the user
// must do so only while the block is idle, which the block does not enforce.
// A character word is held in an input register, then the cursor update
// and its commands go into a four-entry command queue, whose head drives
// the output channel.
// One character is taken per cycle while the queue has two free entries;
// with one command per character and no output stall the rate is one word
// a cycle, and a character that both draws and scrolls gives two commands.
// When the receiver stalls, the queue fills and in_stall rises.
// Reset clears the cursor to the top left, restores the register defaults
// and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tccc_pkg::item_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tccc_pkg::result_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  import tccc_pkg::*;

  cfg_t       cfg;
  item_t      in_q;
  logic       in_q_valid;
  logic [9:0] cursor_col;
  logic [8:0] cursor_row;
  logic [9:0] col_next;
  logic [8:0] row_next;
  logic [1:0] res_cnt;
  result_t    res_first;
  result_t    res_second;
  logic       room;
  logic       advance;
  logic [1:0] push_cnt;

  always_comb begin
    cfg_ready = 1'b1;
    advance   = in_q_valid && room;
    in_stall  = in_q_valid && !room;
    push_cnt  = advance ? res_cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_columns   <= RESET_GRID_COLUMNS;
      cfg.grid_rows      <= RESET_GRID_ROWS;
      cfg.fore_color_reg <= RESET_FORE_COLOR;
      cfg.back_color_reg <= RESET_BACK_COLOR;
      cfg.scroll_block   <= RESET_SCROLL_BLOCK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_COLUMNS: cfg.grid_columns   <= cfg_data[9:0];
        REG_GRID_ROWS:    cfg.grid_rows      <= cfg_data[8:0];
        REG_FORE_COLOR:   cfg.fore_color_reg <= cfg_data;
        REG_BACK_COLOR:   cfg.back_color_reg <= cfg_data;
        REG_SCROLL_BLOCK: cfg.scroll_block   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 10'd0;
      cursor_row <= 9'd0;
    end else if (advance) begin
      cursor_col <= col_next;
      cursor_row <= row_next;
    end
  end

  tccc_step u_step (
    .item       (in_q),
    .cfg        (cfg),
    .col        (cursor_col),
    .row        (cursor_row),
    .col_next   (col_next),
    .row_next   (row_next),
    .res_cnt    (res_cnt),
    .res_first  (res_first),
    .res_second (res_second)
  );

  tccc_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_cnt    (push_cnt),
    .push_first  (res_first),
    .push_second (res_second),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !room) |=> (in_q_valid && $stable(in_q)))
    else $error("held character lost while queue full");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push_cnt == 2'd2) |->
      (res_first.command_kind == CMD_DRAW && res_second.command_kind == CMD_SCROLL))
    else $error("command pair not a draw followed by a scroll");

  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(cursor_col) && $stable(cursor_row)))
    else $error("cursor moved without a character");

endmodule

`default_nettype wire

[sv/tccc_step.sv]
// ----------------------------------------------------------------------------
// Text console cursor step
// Works out the new cursor and up to two drawing commands for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_step (
  input  tccc_pkg::item_t   item,
  input  tccc_pkg::cfg_t    cfg,
  input  logic [9:0]        col,
  input  logic [8:0]        row,
  output logic [9:0]        col_next,
  output logic [8:0]        row_next,
  output logic [1:0]        res_cnt,
  output tccc_pkg::result_t res_first,
  output tccc_pkg::result_t res_second
);
  import tccc_pkg::*;

  logic [9:0]  nl_inc;
  logic        nl_fits;
  logic [8:0]  block_n;
  logic [8:0]  nl_row;
  logic        nl_scroll;
  logic [10:0] tab_sum;
  logic [10:0] tab_t;
  logic [10:0] col_inc;
  logic [9:0]  draw_col;
  logic [7:0]  draw_code;
  result_t     draw_res;
  result_t     scroll_res;
  logic [1:0]  cnt;
  result_t     r0;
  result_t     r1;

  always_comb begin
    nl_inc  = {1'b0, row} + 10'd1;
    nl_fits = nl_inc < {1'b0, cfg.grid_rows};
    block_n = ({2'b0, cfg.scroll_block} > cfg.grid_rows) ?
              cfg.grid_rows : {2'b0, cfg.scroll_block};
    nl_scroll = !nl_fits && !item.in_panic;
    if (nl_fits) begin
      nl_row = nl_inc[8:0];
    end else if (item.in_panic) begin
      nl_row = (cfg.grid_rows != 9'd0) ? cfg.grid_rows - 9'd1 : 9'd0;
    end else begin
      nl_row = cfg.grid_rows - block_n;
    end
  end

  always_comb begin
    tab_sum = {1'b0, col} + 11'(TAB_STEP);
    tab_t   = tab_sum & ~11'(TAB_STEP - 1);
    col_inc = {1'b0, col} + 11'd1;
  end

  always_comb begin
    if (item.char_code == CHAR_BACKSPACE) begin
      draw_col  = col - 10'd1;
      draw_code = CHAR_SPACE;
    end else begin
      draw_col  = col;
      draw_code = item.char_code;
    end
    draw_res.command_kind  = CMD_DRAW;
    draw_res.pixel_x       = 13'({3'b0, draw_col} * 13'(GLYPH_WIDTH));
    draw_res.pixel_y       = 13'({4'b0, row} * 13'(GLYPH_HEIGHT));
    draw_res.glyph_code    = draw_code;
    draw_res.draw_fore     = cfg.fore_color_reg;
    draw_res.draw_back     = cfg.back_color_reg;
    draw_res.scroll_pixels = 13'd0;
    draw_res.last_of_run   = 1'b0;

    scroll_res.command_kind  = CMD_SCROLL;
    scroll_res.pixel_x       = 13'd0;
    scroll_res.pixel_y       = 13'd0;
    scroll_res.glyph_code    = 8'd0;
    scroll_res.draw_fore     = 24'd0;
    scroll_res.draw_back     = cfg.back_color_reg;
    scroll_res.scroll_pixels = 13'({4'b0, block_n} * 13'(GLYPH_HEIGHT));
    scroll_res.last_of_run   = 1'b0;
  end

  always_comb begin
    col_next = col;
    row_next = row;
    cnt      = 2'd0;
    r0       = draw_res;
    r1       = scroll_res;
    case (item.char_code)
      CHAR_NEWLINE: begin
        col_next = 10'd0;
        row_next = nl_row;
        if (nl_scroll) begin
          cnt = 2'd1;
          r0  = scroll_res;
        end
      end
      CHAR_RETURN: begin
        col_next = 10'd0;
      end
      CHAR_BACKSPACE: begin
        if (col != 10'd0) begin
          col_next = col - 10'd1;
          cnt      = 2'd1;
        end
      end
      CHAR_TAB: begin
        if (tab_t >= {1'b0, cfg.grid_columns}) begin
          col_next = 10'd0;
          row_next = nl_row;
          if (nl_scroll) begin
            cnt = 2'd1;
            r0  = scroll_res;
          end
        end else begin
          col_next = tab_t[9:0];
        end
      end
      default: begin
        cnt = 2'd1;
        if (col_inc >= {1'b0, cfg.grid_columns}) begin
          col_next = 10'd0;
          row_next = nl_row;
          if (nl_scroll) begin
            cnt = 2'd2;
          end
        end else begin
          col_next = col_inc[9:0];
        end
      end
    endcase
  end

  always_comb begin
    res_cnt                = cnt;
    res_first              = r0;
    res_first.last_of_run  = (cnt == 2'd1);
    res_second             = r1;
    res_second.last_of_run = 1'b1;
  end

endmodule

`default_nettype wire

[sv/tccc_queue.sv]
// ----------------------------------------------------------------------------
// Text console command queue
// Small result queue taking up to two words a cycle, giving one if unstalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_cnt,
  input  tccc_pkg::result_t push_first,
  input  tccc_pkg::result_t push_second,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output tccc_pkg::result_t out_data
);
  import tccc_pkg::*;

  result_t             entry [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic [QPTR_W-1:0]   wr_ptr_plus;
  logic                pop;

  always_comb begin
    pop         = (count != '0) && !out_stall;
    wr_ptr_plus = wr_ptr + QPTR_W'(1);
    count_next  = count + QCNT_W'(push_cnt) - QCNT_W'(pop);
    room        = count <= QCNT_W'(QDEPTH - 2);
    out_valid   = count != '0;
    out_data    = entry[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_cnt);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entry[wr_ptr] <= push_first;
    end
    if (push_cnt == 2'd2) begin
      entry[wr_ptr_plus] <= push_second;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("command queue count above depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_cnt != 2'd0) |-> room)
    else $error("command queue written without room");

  a_stalled_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(rd_ptr) && out_valid))
    else $error("queue head moved while stalled");

endmodule

`default_nettype wire
